// ===== rtl/mic1_pkg.sv =====
// Shared types and constants for the Mic-1 microinstruction datapath.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mic1_pkg;

    localparam int DEF_MEM_WORDS = 1024;
    localparam int NREGS         = 9;
    localparam int WORD_W        = 32;

    // register file order follows the C-bus mask bits
    localparam int REG_MAR = 0;
    localparam int REG_MDR = 1;
    localparam int REG_PC  = 2;
    localparam int REG_SP  = 3;
    localparam int REG_LV  = 4;
    localparam int REG_CPP = 5;
    localparam int REG_TOS = 6;
    localparam int REG_OPC = 7;
    localparam int REG_H   = 8;
    localparam logic [3:0] SEL_MBR = 4'd9;

    // B-bus select codes
    localparam logic [3:0] BSEL_MDR   = 4'd0;
    localparam logic [3:0] BSEL_PC    = 4'd1;
    localparam logic [3:0] BSEL_MBR_U = 4'd2;
    localparam logic [3:0] BSEL_MBR_S = 4'd3;
    localparam logic [3:0] BSEL_SP    = 4'd4;
    localparam logic [3:0] BSEL_LV    = 4'd5;
    localparam logic [3:0] BSEL_CPP   = 4'd6;
    localparam logic [3:0] BSEL_TOS   = 4'd7;
    localparam logic [3:0] BSEL_OPC   = 4'd8;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int RES_W       = 228;
    localparam int OUT_TDATA_W = 232;

    typedef enum logic [1:0] {
        OP_EXEC        = 2'd0,
        OP_PRELOAD_REG = 2'd1,
        OP_PRELOAD_MEM = 2'd2,
        OP_NOP         = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2,
        MEM_FETCH = 2'd3
    } t_mem_code;

    typedef enum logic [1:0] {
        FN_AND  = 2'd0,
        FN_OR   = 2'd1,
        FN_NOTB = 2'd2,
        FN_ADD  = 2'd3
    } t_alu_fn;

    typedef struct packed {
        logic    sll8;
        logic    sra1;
        t_alu_fn fn;
        logic    ena;
        logic    enb;
        logic    inva;
        logic    inc;
    } t_alu_ctl;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              carry;
    } t_alu_res;

    // first field sits in the top bits, so alu_value lands at bit 0 of tdata
    typedef struct packed {
        logic              mem_fault;
        logic [WORD_W-1:0] h_now;
        logic [WORD_W-1:0] tos_now;
        logic [WORD_W-1:0] sp_now;
        logic [WORD_W-1:0] pc_now;
        logic [WORD_W-1:0] mdr_now;
        logic [WORD_W-1:0] mar_now;
        logic              carry_out;
        logic              flag_zero;
        logic              flag_negative;
        logic [WORD_W-1:0] alu_value;
    } t_result;

endpackage

// ===== rtl/mic1_alu.sv =====
// Mic-1 B-bus source select, ALU and shifter.
// Depends on mic1_pkg.
`timescale 1ns / 1ps

module mic1_alu
    import mic1_pkg::*;
(
    input  t_alu_ctl                     i_ctl,
    input  logic [3:0]                   i_bsel,
    input  logic [NREGS-1:0][WORD_W-1:0] i_rf,
    input  logic [7:0]                   i_mbr,
    output t_alu_res                     o_res
);

    logic [WORD_W-1:0] bus_b;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] s;
    logic [WORD_W:0]   sum;

    always_comb begin
        case (i_bsel)
            BSEL_MDR:   bus_b = i_rf[REG_MDR];
            BSEL_PC:    bus_b = i_rf[REG_PC];
            BSEL_MBR_U: bus_b = {24'd0, i_mbr};
            BSEL_MBR_S: bus_b = {{24{i_mbr[7]}}, i_mbr};
            BSEL_SP:    bus_b = i_rf[REG_SP];
            BSEL_LV:    bus_b = i_rf[REG_LV];
            BSEL_CPP:   bus_b = i_rf[REG_CPP];
            BSEL_TOS:   bus_b = i_rf[REG_TOS];
            BSEL_OPC:   bus_b = i_rf[REG_OPC];
            default:    bus_b = '0;
        endcase
    end

    always_comb begin
        x   = i_ctl.ena ? i_rf[REG_H] : '0;
        x   = i_ctl.inva ? ~x : x;
        y   = i_ctl.enb ? bus_b : '0;
        sum = {1'b0, x} + {1'b0, y} + {{WORD_W{1'b0}}, i_ctl.inc};
        o_res.carry = 1'b0;
        case (i_ctl.fn)
            FN_AND:  s = x & y;
            FN_OR:   s = x | y;
            FN_NOTB: s = ~y;
            FN_ADD: begin
                s           = sum[WORD_W-1:0];
                o_res.carry = sum[WORD_W];
            end
            default: s = '0;
        endcase
        // SLL8 wins over SRA1
        if (i_ctl.sll8) begin
            o_res.value = {s[WORD_W-9:0], 8'd0};
        end else if (i_ctl.sra1) begin
            o_res.value = {s[WORD_W-1], s[WORD_W-1:1]};
        end else begin
            o_res.value = s;
        end
    end

endmodule

// ===== rtl/mic1_mem.sv =====
// Main store: single-port synchronous RAM with registered read data and a
// zero-fill sweep after reset. Depends on mic1_pkg.
`timescale 1ns / 1ps

module mic1_mem
    import mic1_pkg::*;
#(
    parameter  int MEM_WORDS = DEF_MEM_WORDS,
    localparam int AW        = $clog2(MEM_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata,
    output logic              o_busy
);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [AW-1:0]     r_clr_addr;
    logic              r_busy;
    logic [WORD_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MEM_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_en && i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_en && !i_we) begin
            r_q <= mem[i_addr];
        end
    end

    assign o_rdata = r_q;
    assign o_busy  = r_busy;

endmodule

// ===== rtl/mic1_microinstruction_datapath_top.sv =====
// Mic-1 microinstruction datapath top: register file, beat control, result stages.
// Depends on mic1_pkg, mic1_alu and mic1_mem.
`timescale 1ns / 1ps

// Each beat runs a microinstruction, preloads a register, preloads a memory word
// or does nothing (NOP). Beats are taken back to back, one per cycle, as long as
// results are drained; each result passes through a stage register while the
// main store read completes, then through the output register.
// A memory read's data is forwarded into MDR for the very next beat, so reads do
// not stall. After reset the main store is zero-filled, one word per cycle, so
// s_axis_tready stays low until the sweep has cleared every word.
module mic1_microinstruction_datapath_top
    import mic1_pkg::*;
#(
    parameter int MEM_WORDS = DEF_MEM_WORDS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // micro_word[22:0], reg_select[26:23], load_address[36:27],
    // load_value[68:37], zero pad [71:69]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // alu_value[31:0], flag_negative[32], flag_zero[33], carry_out[34],
    // mar_now[66:35], mdr_now[98:67], pc_now[130:99], sp_now[162:131],
    // tos_now[194:163], h_now[226:195], mem_fault[227], zero pad [231:228]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [NREGS-1:0][WORD_W-1:0] r_rf;
    logic [NREGS-1:0][WORD_W-1:0] n_rf;
    logic [NREGS-1:0][WORD_W-1:0] rf_cur;
    logic [7:0]                   r_mbr;
    logic [7:0]                   n_mbr;
    logic                         r_rd_pend;
    logic                         n_rd_pend;

    logic                         r_s1_v;
    logic                         r_s1_rd;
    t_result                      r_s1;
    t_result                      s1_fwd;
    t_result                      res;
    logic                         r_out_v;
    t_result                      r_out;

    logic                         out_free;
    logic                         s1_free;
    logic                         mem_busy;
    logic                         accept;

    logic                         mem_en;
    logic                         mem_we;
    logic [WORD_W-1:0]            mem_addr;
    logic [WORD_W-1:0]            mem_wdata;
    logic [WORD_W-1:0]            mem_q;

    logic [22:0]                  word;
    t_alu_ctl                     ctl;
    logic [8:0]                   cmask;
    t_mem_code                    mcode;
    logic [3:0]                   bsel;
    logic [3:0]                   rsel;
    logic [WORD_W-1:0]            ld_addr;
    logic [WORD_W-1:0]            ld_val;
    t_alu_res                     alu;

    assign word    = s_axis_tdata[22:0];
    assign ctl     = t_alu_ctl'(word[22:15]);
    assign cmask   = word[14:6];
    assign mcode   = t_mem_code'(word[5:4]);
    assign bsel    = word[3:0];
    assign rsel    = s_axis_tdata[26:23];
    assign ld_addr = {22'd0, s_axis_tdata[36:27]};
    assign ld_val  = s_axis_tdata[68:37];

    assign out_free      = !r_out_v || m_axis_tready;
    assign s1_free       = !r_s1_v || out_free;
    assign s_axis_tready = !mem_busy && s1_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // MDR forward: the read issued by the previous beat lands now
    always_comb begin
        rf_cur          = r_rf;
        rf_cur[REG_MDR] = r_rd_pend ? mem_q : r_rf[REG_MDR];
    end

    mic1_alu u_alu (
        .i_ctl  (ctl),
        .i_bsel (bsel),
        .i_rf   (rf_cur),
        .i_mbr  (r_mbr),
        .o_res  (alu)
    );

    always_comb begin
        n_rf      = rf_cur;
        n_mbr     = r_mbr;
        n_rd_pend = 1'b0;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        res       = '0;
        if (accept) begin
            case (t_op'(s_axis_tuser))
                OP_EXEC: begin
                    if (mcode == MEM_FETCH) begin
                        n_mbr        = word[22:15];
                        n_rf[REG_H]  = {24'd0, word[22:15]};
                    end else begin
                        res.alu_value     = alu.value;
                        res.carry_out     = alu.carry;
                        res.flag_negative = alu.value[WORD_W-1];
                        res.flag_zero     = (alu.value == '0);
                        for (int i = 0; i < NREGS; i++) begin
                            if (cmask[i]) begin
                                n_rf[i] = alu.value;
                            end
                        end
                    end
                    if (mcode == MEM_READ || mcode == MEM_WRITE) begin
                        mem_addr  = n_rf[REG_MAR];
                        mem_wdata = n_rf[REG_MDR];
                        if (n_rf[REG_MAR] >= WORD_W'(MEM_WORDS)) begin
                            res.mem_fault = 1'b1;
                            if (mcode == MEM_READ) begin
                                n_rf[REG_MDR] = '0;
                            end
                        end else begin
                            mem_en    = 1'b1;
                            mem_we    = (mcode == MEM_WRITE);
                            n_rd_pend = (mcode == MEM_READ);
                        end
                    end
                end
                OP_PRELOAD_REG: begin
                    for (int i = 0; i < NREGS; i++) begin
                        if (rsel == 4'(i)) begin
                            n_rf[i] = ld_val;
                        end
                    end
                    if (rsel == SEL_MBR) begin
                        n_mbr = ld_val[7:0];
                    end
                end
                OP_PRELOAD_MEM: begin
                    mem_addr  = ld_addr;
                    mem_wdata = ld_val;
                    if (ld_addr >= WORD_W'(MEM_WORDS)) begin
                        res.mem_fault = 1'b1;
                    end else begin
                        mem_en = 1'b1;
                        mem_we = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        res.mar_now = n_rf[REG_MAR];
        res.mdr_now = n_rf[REG_MDR];
        res.pc_now  = n_rf[REG_PC];
        res.sp_now  = n_rf[REG_SP];
        res.tos_now = n_rf[REG_TOS];
        res.h_now   = n_rf[REG_H];
    end

    mic1_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr[AW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (mem_q),
        .o_busy  (mem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf      <= '0;
            r_mbr     <= '0;
            r_rd_pend <= 1'b0;
            r_s1_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_rf      <= n_rf;
            r_mbr     <= n_mbr;
            r_rd_pend <= n_rd_pend;
            if (s1_free) begin
                r_s1_v <= accept;
            end
            if (out_free) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    // a read beat picks up the store data on its way to the output register
    always_comb begin
        s1_fwd = r_s1;
        if (r_s1_rd) begin
            s1_fwd.mdr_now = mem_q;
        end
    end

    // store read data is held until the next read, which can only be issued
    // on the cycle this stage moves on
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1    <= res;
            r_s1_rd <= n_rd_pend;
        end
        if (out_free && r_s1_v) begin
            r_out <= s1_fwd;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_out};

endmodule

// ===== rtl/mic1_chk.sv =====
// Port-level checker for the Mic-1 datapath top, bound to it below.
// Depends on mic1_pkg.
`timescale 1ns / 1ps

module mic1_chk
    import mic1_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // store clear sweep keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input open during store clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // beats without an ALU pass report a zero value with the zero flag clear
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("zero flag set with nonzero ALU value");

    a_neg_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[32] == m_axis_tdata[31])
        else $error("negative flag does not match ALU value");

endmodule

bind mic1_microinstruction_datapath_top mic1_chk u_mic1_chk (.*);
